[rtl/core/swmd_pkg.sv]
// ----------------------------------------------------------------------------
// swmd_pkg: shared types, constants and microprogram of the middle-delete stack
// Holds the slot and count types, the control word layout, the step
// addresses and the read-only control store used by the sequencer.
// ----------------------------------------------------------------------------
package swmd_pkg;

    localparam int DEPTH  = 256;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int STEP_W = 5;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [STEP_W-1:0] t_step;

    // command codes on the input beat
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DELMID = 2'd2,
        CMD_REPORT = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // jump conditions, evaluated on the count before the step's update
    typedef enum logic [2:0] {
        C_NEVER  = 3'd0,
        C_ALWAYS = 3'd1,
        C_ZERO   = 3'd2,
        C_ONE    = 3'd3,
        C_TWO    = 3'd4,
        C_FULL   = 3'd5,
        C_EVEN   = 3'd6
    } t_cond;

    typedef enum logic [1:0] {
        TOP_KEEP = 2'd0,
        TOP_SLOT = 2'd1,
        TOP_DN   = 2'd2,
        TOP_ZERO = 2'd3
    } t_top_op;

    typedef enum logic [2:0] {
        MID_KEEP = 3'd0,
        MID_SLOT = 3'd1,
        MID_UP   = 3'd2,
        MID_DN   = 3'd3,
        MID_DEL  = 3'd4,
        MID_ZERO = 3'd5
    } t_mid_op;

    typedef enum logic [1:0] {
        CNT_KEEP = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    typedef enum logic [1:0] {
        GV_NONE = 2'd0,
        GV_TOP  = 2'd1,
        GV_MID  = 2'd2
    } t_give;

    // link memory read address select
    typedef enum logic {
        LA_TOP = 1'b0,
        LA_MID = 1'b1
    } t_la;

    // one control word of the microprogram
    typedef struct packed {
        logic    fetch;
        logic    emit;
        t_la     la_sel;
        logic    alloc;
        logic    unlink;
        t_give   give;
        t_top_op top_op;
        t_mid_op mid_op;
        t_cnt_op cnt_op;
        logic    st_we;
        t_status st_code;
        t_cond   cond;
        t_step   target;
    } t_uword;

    // condition flags from the datapath
    typedef struct packed {
        logic zero;
        logic one;
        logic two;
        logic full;
        logic even;
    } t_flags;

    // step addresses
    localparam t_step S_IDLE      = 5'd0;
    localparam t_step S_PU0       = 5'd1;
    localparam t_step S_PU1       = 5'd2;
    localparam t_step S_PU2       = 5'd3;
    localparam t_step S_PU3       = 5'd4;
    localparam t_step S_PU4       = 5'd5;
    localparam t_step S_PU_FIRST  = 5'd6;
    localparam t_step S_PO0       = 5'd7;
    localparam t_step S_PO1       = 5'd8;
    localparam t_step S_PO2       = 5'd9;
    localparam t_step S_PO3       = 5'd10;
    localparam t_step S_PO_LAST   = 5'd11;
    localparam t_step S_DM0       = 5'd12;
    localparam t_step S_DM1       = 5'd13;
    localparam t_step S_DM2       = 5'd14;
    localparam t_step S_DM3       = 5'd15;
    localparam t_step S_DM_ONE    = 5'd16;
    localparam t_step S_DM_TWO    = 5'd17;
    localparam t_step S_ERR_EMPTY = 5'd18;
    localparam t_step S_ERR_FULL  = 5'd19;
    localparam t_step S_OUT       = 5'd20;
    localparam t_step S_EMIT      = 5'd21;

    localparam t_uword UW_NOP = '{
        fetch:   1'b0,
        emit:    1'b0,
        la_sel:  LA_MID,
        alloc:   1'b0,
        unlink:  1'b0,
        give:    GV_NONE,
        top_op:  TOP_KEEP,
        mid_op:  MID_KEEP,
        cnt_op:  CNT_KEEP,
        st_we:   1'b0,
        st_code: STAT_DONE,
        cond:    C_NEVER,
        target:  S_IDLE
    };

    // program entry point for each command
    function automatic t_step entry(input t_cmd c);
        t_step s;
        begin
            unique case (c)
                CMD_PUSH:   s = S_PU0;
                CMD_POP:    s = S_PO0;
                CMD_DELMID: s = S_DM0;
                CMD_REPORT: s = S_OUT;
                default:    s = S_OUT;
            endcase
            return s;
        end
    endfunction

    // control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        begin
            w = UW_NOP;
            unique case (s)
                S_IDLE: begin
                    w.fetch = 1'b1;
                end
                // push: check room, take a slot, link it, move the middle
                S_PU0: begin
                    w.cond   = C_FULL;
                    w.target = S_ERR_FULL;
                end
                S_PU1: begin
                    w.alloc = 1'b1;
                end
                S_PU2: begin
                    w.cond   = C_ZERO;
                    w.target = S_PU_FIRST;
                end
                S_PU3: begin
                    w.top_op = TOP_SLOT;
                    w.cnt_op = CNT_INC;
                    w.cond   = C_EVEN;
                    w.target = S_OUT;
                end
                S_PU4: begin
                    w.mid_op = MID_UP;
                    w.cond   = C_ALWAYS;
                    w.target = S_OUT;
                end
                S_PU_FIRST: begin
                    w.top_op = TOP_SLOT;
                    w.mid_op = MID_SLOT;
                    w.cnt_op = CNT_INC;
                    w.cond   = C_ALWAYS;
                    w.target = S_OUT;
                end
                // pop: free the top slot, step top down, maybe the middle too
                S_PO0: begin
                    w.la_sel = LA_TOP;
                    w.cond   = C_ZERO;
                    w.target = S_ERR_EMPTY;
                end
                S_PO1: begin
                    w.give   = GV_TOP;
                    w.top_op = TOP_DN;
                    w.cnt_op = CNT_DEC;
                    w.cond   = C_ONE;
                    w.target = S_PO_LAST;
                end
                S_PO2: begin
                    w.cond   = C_EVEN;
                    w.target = S_OUT;
                end
                S_PO3: begin
                    w.mid_op = MID_DN;
                    w.cond   = C_ALWAYS;
                    w.target = S_OUT;
                end
                S_PO_LAST: begin
                    w.top_op = TOP_ZERO;
                    w.mid_op = MID_ZERO;
                    w.cond   = C_ALWAYS;
                    w.target = S_OUT;
                end
                // delete middle: read neighbor links, splice, free the slot
                S_DM0: begin
                    w.cond   = C_ZERO;
                    w.target = S_ERR_EMPTY;
                end
                S_DM1: begin
                    w.cond   = C_ONE;
                    w.target = S_DM_ONE;
                end
                S_DM2: begin
                    w.cond   = C_TWO;
                    w.target = S_DM_TWO;
                end
                S_DM3: begin
                    w.unlink = 1'b1;
                    w.give   = GV_MID;
                    w.mid_op = MID_DEL;
                    w.cnt_op = CNT_DEC;
                    w.cond   = C_ALWAYS;
                    w.target = S_OUT;
                end
                S_DM_ONE: begin
                    w.give   = GV_TOP;
                    w.top_op = TOP_ZERO;
                    w.mid_op = MID_ZERO;
                    w.cnt_op = CNT_DEC;
                    w.cond   = C_ALWAYS;
                    w.target = S_OUT;
                end
                S_DM_TWO: begin
                    w.give   = GV_MID;
                    w.top_op = TOP_DN;
                    w.mid_op = MID_DN;
                    w.cnt_op = CNT_DEC;
                    w.cond   = C_ALWAYS;
                    w.target = S_OUT;
                end
                S_ERR_EMPTY: begin
                    w.st_we   = 1'b1;
                    w.st_code = STAT_EMPTY;
                    w.cond    = C_ALWAYS;
                    w.target  = S_OUT;
                end
                S_ERR_FULL: begin
                    w.st_we   = 1'b1;
                    w.st_code = STAT_FULL;
                    w.cond    = C_ALWAYS;
                    w.target  = S_OUT;
                end
                // value reads for the result are issued here
                S_OUT: begin
                    w.cond = C_NEVER;
                end
                S_EMIT: begin
                    w.emit   = 1'b1;
                    w.cond   = C_ALWAYS;
                    w.target = S_IDLE;
                end
                default: begin
                    w.cond   = C_ALWAYS;
                    w.target = S_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

[rtl/core/stack_with_middle_delete.sv]
// ----------------------------------------------------------------------------
// stack_with_middle_delete: bounded stack with middle tracking and delete
// Signed 32-bit stack of swmd_pkg::DEPTH entries held as a doubly linked
// list in slot memories, with a pointer to the middle element.
//
// Input channel (i_in_valid / o_in_ready): one beat carries a command
// (push, pop, delete middle, report) and a value used by push.
// Output channel (o_out_valid / i_out_ready): exactly one result beat per
// input beat: top value, middle value, empty flag, count and status.
// Pop or delete on an empty stack and push on a full one change nothing
// and report the reason in the status field.
//
// One command is worked at a time by a microprogrammed sequencer, which
// walks that command's microprogram path one step per cycle, save while
// a stalled receiver holds it; the path length is set by the registered
// reads of the link memories.
// The next beat is taken the cycle after the result is loaded, even while
// that result still waits to be taken. A stalled receiver holds the block
// in its last step once a new result is ready. Synchronous reset empties
// the stack at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_with_middle_delete (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_value_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_top_value,
    output logic signed [31:0] o_middle_value,
    output logic               o_empty_flag,
    output logic [8:0]         o_entry_count,
    output logic [1:0]         o_status
);

    localparam int DEPTH  = swmd_pkg::DEPTH;
    localparam int SLOT_W = swmd_pkg::SLOT_W;
    localparam int CNT_W  = swmd_pkg::CNT_W;
    localparam int DATA_W = swmd_pkg::DATA_W;

    // slot memories
    logic [DATA_W-1:0] m_val [DEPTH];
    logic [SLOT_W-1:0] m_up  [DEPTH];
    logic [SLOT_W-1:0] m_dn  [DEPTH];
    logic [SLOT_W-1:0] m_fs  [DEPTH];

    // control and pointer state
    swmd_pkg::t_uword  uw;
    swmd_pkg::t_flags  flags;
    swmd_pkg::t_status r_status;
    swmd_pkg::t_slot   r_top;
    swmd_pkg::t_slot   r_mid;
    swmd_pkg::t_cnt    r_cnt;
    swmd_pkg::t_cnt    r_fcnt;
    swmd_pkg::t_cnt    r_fresh;
    logic [DATA_W-1:0] r_value;
    swmd_pkg::t_slot   r_new_slot;

    // registered memory read data
    swmd_pkg::t_slot   r_rd_up;
    swmd_pkg::t_slot   r_rd_dn;
    swmd_pkg::t_slot   r_rd_fs;
    logic [DATA_W-1:0] r_rd_top_val;
    logic [DATA_W-1:0] r_rd_mid_val;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_top;
    logic [DATA_W-1:0] r_out_mid;
    logic              r_out_empty;
    swmd_pkg::t_cnt    r_out_cnt;
    swmd_pkg::t_status r_out_status;

    logic              take;
    logic              out_busy;
    swmd_pkg::t_slot   link_ra;
    swmd_pkg::t_slot   fs_ra;
    swmd_pkg::t_slot   alloc_slot;
    swmd_pkg::t_slot   give_slot;
    logic              up_we;
    swmd_pkg::t_slot   up_wa;
    swmd_pkg::t_slot   up_wd;
    logic              dn_we;
    swmd_pkg::t_slot   dn_wa;
    swmd_pkg::t_slot   dn_wd;

    assign take       = uw.fetch & i_in_valid;
    assign out_busy   = r_out_valid & ~i_out_ready;
    assign o_in_ready = uw.fetch;

    assign flags.zero = (r_cnt == '0);
    assign flags.one  = (r_cnt == CNT_W'(1));
    assign flags.two  = (r_cnt == CNT_W'(2));
    assign flags.full = (r_cnt == CNT_W'(DEPTH));
    assign flags.even = ~r_cnt[0];

    swmd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_cmd      (i_cmd),
        .i_flags    (flags),
        .i_out_busy (out_busy),
        .o_uw       (uw)
    );

    // read addresses
    assign link_ra = (uw.la_sel == swmd_pkg::LA_MID) ? r_mid : r_top;
    assign fs_ra   = SLOT_W'(r_fcnt - 1'b1);

    // reuse a freed slot when one is stacked, else hand out a fresh one
    assign alloc_slot = (r_fcnt != '0) ? r_rd_fs : r_fresh[SLOT_W-1:0];
    assign give_slot  = (uw.give == swmd_pkg::GV_MID) ? r_mid : r_top;

    // link write ports: push links the new slot, delete splices neighbors
    always_comb begin
        up_we = 1'b0;
        up_wa = r_top;
        up_wd = alloc_slot;
        dn_we = 1'b0;
        dn_wa = alloc_slot;
        dn_wd = r_top;
        if (uw.alloc) begin
            up_we = 1'b1;
            dn_we = 1'b1;
        end else if (uw.unlink) begin
            up_we = 1'b1;
            up_wa = r_rd_dn;
            up_wd = r_rd_up;
            dn_we = 1'b1;
            dn_wa = r_rd_up;
            dn_wd = r_rd_dn;
        end
    end

    // write and read the slot memories
    always_ff @(posedge i_clk) begin
        if (uw.alloc) begin
            m_val[alloc_slot] <= r_value;
        end
        if (up_we) begin
            m_up[up_wa] <= up_wd;
        end
        if (dn_we) begin
            m_dn[dn_wa] <= dn_wd;
        end
        if (uw.give != swmd_pkg::GV_NONE) begin
            m_fs[r_fcnt[SLOT_W-1:0]] <= give_slot;
        end
        r_rd_up      <= m_up[link_ra];
        r_rd_dn      <= m_dn[link_ra];
        r_rd_fs      <= m_fs[fs_ra];
        r_rd_top_val <= m_val[r_top];
        r_rd_mid_val <= m_val[r_mid];
    end

    // hold the pushed value
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value <= i_value_in;
        end
    end

    // hold the slot just taken for the later pointer steps
    always_ff @(posedge i_clk) begin
        if (uw.alloc) begin
            r_new_slot <= alloc_slot;
        end
    end

    // update pointers, counts and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_mid    <= '0;
            r_cnt    <= '0;
            r_fcnt   <= '0;
            r_fresh  <= '0;
            r_status <= swmd_pkg::STAT_DONE;
        end else begin
            if (take) begin
                r_status <= swmd_pkg::STAT_DONE;
            end else if (uw.st_we) begin
                r_status <= uw.st_code;
            end

            case (uw.top_op)
                swmd_pkg::TOP_SLOT: r_top <= r_new_slot;
                swmd_pkg::TOP_DN:   r_top <= r_rd_dn;
                swmd_pkg::TOP_ZERO: r_top <= '0;
                default:            r_top <= r_top;
            endcase

            case (uw.mid_op)
                swmd_pkg::MID_SLOT: r_mid <= r_new_slot;
                swmd_pkg::MID_UP:   r_mid <= r_rd_up;
                swmd_pkg::MID_DN:   r_mid <= r_rd_dn;
                swmd_pkg::MID_DEL:  r_mid <= flags.even ? r_rd_dn : r_rd_up;
                swmd_pkg::MID_ZERO: r_mid <= '0;
                default:            r_mid <= r_mid;
            endcase

            case (uw.cnt_op)
                swmd_pkg::CNT_INC: r_cnt <= CNT_W'(r_cnt + 1'b1);
                swmd_pkg::CNT_DEC: r_cnt <= CNT_W'(r_cnt - 1'b1);
                default:           r_cnt <= r_cnt;
            endcase

            // free slot stack and fresh slot counter
            if (uw.alloc) begin
                if (r_fcnt != '0) begin
                    r_fcnt <= CNT_W'(r_fcnt - 1'b1);
                end else begin
                    r_fresh <= CNT_W'(r_fresh + 1'b1);
                end
            end else if (uw.give != swmd_pkg::GV_NONE) begin
                r_fcnt <= CNT_W'(r_fcnt + 1'b1);
            end
        end
    end

    // load the result beat, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.emit && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.emit && !out_busy) begin
            r_out_top    <= flags.zero ? '0 : r_rd_top_val;
            r_out_mid    <= flags.zero ? '0 : r_rd_mid_val;
            r_out_empty  <= flags.zero;
            r_out_cnt    <= r_cnt;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_top_value    = $signed(r_out_top);
    assign o_middle_value = $signed(r_out_mid);
    assign o_empty_flag   = r_out_empty;
    assign o_entry_count  = 9'(r_out_cnt);
    assign o_status       = r_out_status;

    // count never passes capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    // between commands every handed-out slot is either held or stacked free
    a_slot_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uw.fetch |-> ((CNT_W+1)'(r_fresh) == (CNT_W+1)'(r_cnt) + (CNT_W+1)'(r_fcnt)))
        else $error("slot accounting mismatch");

    // empty flag agrees with the reported count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_empty == (r_out_cnt == '0)))
        else $error("empty flag disagrees with count");

    // a new input beat is never taken while a command is in progress
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !uw.fetch)
        else $error("input accepted mid-command");

endmodule

[rtl/core/swmd_seq.sv]
// ----------------------------------------------------------------------------
// swmd_seq: microprogram sequencer
// Step counter over the control store, with dispatch on the command at
// fetch, conditional jumps on datapath flags and a hold while a result
// waits in the output register.
// ----------------------------------------------------------------------------
module swmd_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [1:0]        i_cmd,
    input  swmd_pkg::t_flags  i_flags,
    input  logic              i_out_busy,
    output swmd_pkg::t_uword  o_uw
);

    swmd_pkg::t_step  r_step;
    swmd_pkg::t_step  n_step;
    swmd_pkg::t_uword uw;
    logic             cond_hit;

    // decode the current control word
    assign uw   = swmd_pkg::ucode(r_step);
    assign o_uw = uw;

    // evaluate the jump condition
    always_comb begin
        case (uw.cond)
            swmd_pkg::C_NEVER:  cond_hit = 1'b0;
            swmd_pkg::C_ALWAYS: cond_hit = 1'b1;
            swmd_pkg::C_ZERO:   cond_hit = i_flags.zero;
            swmd_pkg::C_ONE:    cond_hit = i_flags.one;
            swmd_pkg::C_TWO:    cond_hit = i_flags.two;
            swmd_pkg::C_FULL:   cond_hit = i_flags.full;
            swmd_pkg::C_EVEN:   cond_hit = i_flags.even;
            default:            cond_hit = 1'b0;
        endcase
    end

    // pick the next step
    always_comb begin
        priority if (uw.fetch) begin
            n_step = i_take ? swmd_pkg::entry(swmd_pkg::t_cmd'(i_cmd)) : r_step;
        end else if (uw.emit && i_out_busy) begin
            n_step = r_step;
        end else if (cond_hit) begin
            n_step = uw.target;
        end else begin
            n_step = swmd_pkg::STEP_W'(r_step + 1'b1);
        end
    end

    // advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= swmd_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
